### rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helpers of the wheel odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int MUL_W = 34;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic signed [31:0] TWO_PI_Q28 = 32'sd1686629713;
    localparam logic signed [31:0] PI_Q28 = 32'sd843314856;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [31:0] CORDIC_GAIN_Q28 = 32'sd163008219;

    localparam int MOD_STEPS = 24;

    typedef enum logic [1:0] {
        CFG_DIST_PER_TICK = 2'd0,
        CFG_INV_WHEEL_SEP = 2'd1,
        CFG_LIN_GAIN = 2'd2,
        CFG_ANG_GAIN = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_TURN_A,
        ST_TURN_B,
        ST_LIN_FILT,
        ST_ANG_FILT,
        ST_HEAD_SET,
        ST_HEAD_MOD,
        ST_HEAD_FIN,
        ST_CORD_INIT,
        ST_CORD,
        ST_POS_X,
        ST_POS_Y,
        ST_DONE
    } t_state;

    function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
        case (idx)
            5'd0: atan_q28 = 32'sd210828714;
            5'd1: atan_q28 = 32'sd124459457;
            5'd2: atan_q28 = 32'sd65760959;
            5'd3: atan_q28 = 32'sd33381290;
            5'd4: atan_q28 = 32'sd16755422;
            5'd5: atan_q28 = 32'sd8385879;
            5'd6: atan_q28 = 32'sd4193963;
            5'd7: atan_q28 = 32'sd2097109;
            5'd8: atan_q28 = 32'sd1048571;
            5'd9: atan_q28 = 32'sd524287;
            5'd10: atan_q28 = 32'sd262144;
            5'd11: atan_q28 = 32'sd131072;
            5'd12: atan_q28 = 32'sd65536;
            5'd13: atan_q28 = 32'sd32768;
            5'd14: atan_q28 = 32'sd16384;
            5'd15: atan_q28 = 32'sd8192;
            5'd16: atan_q28 = 32'sd4096;
            5'd17: atan_q28 = 32'sd2048;
            5'd18: atan_q28 = 32'sd1024;
            5'd19: atan_q28 = 32'sd512;
            5'd20: atan_q28 = 32'sd256;
            5'd21: atan_q28 = 32'sd128;
            5'd22: atan_q28 = 32'sd64;
            5'd23: atan_q28 = 32'sd32;
            5'd24: atan_q28 = 32'sd16;
            5'd25: atan_q28 = 32'sd8;
            5'd26: atan_q28 = 32'sd4;
            5'd27: atan_q28 = 32'sd2;
            default: atan_q28 = 32'sd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        if (v > $signed(PROD_W'(64'sh7FFFFFFF))) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < -$signed(PROD_W'(64'sh80000000))) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [PROD_W-1:0] v);
        if (v > $signed(PROD_W'(64'sh7FFFFFFFFFFF))) begin
            sat48 = 48'sh7FFFFFFFFFFF;
        end else if (v < -$signed(PROD_W'(64'sh800000000000))) begin
            sat48 = 48'sh800000000000;
        end else begin
            sat48 = v[47:0];
        end
    endfunction

endpackage

### rtl/ddo_in_if.sv
// ----------------------------------------------------------------------------
// ddo_in_if
// Request channel: wheel tick deltas and time step.
// ----------------------------------------------------------------------------
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_delta;
    logic signed [15:0] right_delta;
    logic [15:0]        time_step;

    modport source (output valid, output left_delta, output right_delta,
                    output time_step, input ready);
    modport sink (input valid, input left_delta, input right_delta,
                  input time_step, output ready);
endinterface

### rtl/ddo_out_if.sv
// ----------------------------------------------------------------------------
// ddo_out_if
// Result channel: pose, filtered rates and tick totals.
// ----------------------------------------------------------------------------
interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [30:0] heading_angle;
    logic signed [31:0] linear_rate;
    logic signed [31:0] angular_rate;
    logic signed [31:0] left_total;
    logic signed [31:0] right_total;

    modport source (output valid, output pos_x, output pos_y, output heading_angle,
                    output linear_rate, output angular_rate, output left_total,
                    output right_total, input ready);
    modport sink (input valid, input pos_x, input pos_y, input heading_angle,
                  input linear_rate, input angular_rate, input left_total,
                  input right_total, output ready);
endinterface

### rtl/ddo_mul.sv
// ----------------------------------------------------------------------------
// ddo_mul
// Bit-serial signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [ddo_pkg::MUL_W-1:0]      i_a,
    input  logic signed [ddo_pkg::MUL_W-1:0]      i_b,
    output logic                                  o_done,
    output logic signed [ddo_pkg::PROD_W-1:0]     o_p
);
    localparam int CW = $clog2(ddo_pkg::MUL_W);

    logic                            r_busy;
    logic                            r_done;
    logic [CW-1:0]                   r_cnt;
    logic signed [ddo_pkg::MUL_W-1:0] r_a;
    logic [ddo_pkg::MUL_W-1:0]       r_hi;
    logic [ddo_pkg::MUL_W-1:0]       r_lo;
    logic [ddo_pkg::MUL_W:0]         n_sum;
    logic [ddo_pkg::MUL_W:0]         w_addend;
    logic                            w_last;

    always_comb begin
        w_last = (r_cnt == CW'(ddo_pkg::MUL_W - 1));
        if (!r_lo[0]) begin
            w_addend = '0;
        end else if (w_last) begin
            w_addend = -{r_a[ddo_pkg::MUL_W-1], r_a};
        end else begin
            w_addend = {r_a[ddo_pkg::MUL_W-1], r_a};
        end
        n_sum = {r_hi[ddo_pkg::MUL_W-1], r_hi} + w_addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_a <= i_a;
                r_hi <= '0;
                r_lo <= i_b;
            end else if (r_busy) begin
                r_hi <= n_sum[ddo_pkg::MUL_W:1];
                r_lo <= {n_sum[0], r_lo[ddo_pkg::MUL_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p = {r_hi, r_lo};
endmodule

### rtl/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div
// Restoring unsigned divider, 32 by 16 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddo_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quo
);
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_q;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [16:0] n_rem2;
    logic        n_fit;

    always_comb begin
        n_rem2 = {r_rem, r_q[31]};
        n_fit = (n_rem2 >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_q <= i_num;
                r_rem <= '0;
                r_den <= i_den;
            end else if (r_busy) begin
                r_rem <= n_fit ? 16'(n_rem2 - {1'b0, r_den}) : n_rem2[15:0];
                r_q <= {r_q[30:0], n_fit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo = r_q;
endmodule

### rtl/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Differential-drive wheel odometry with filtered rates and CORDIC pose update.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per encoder sample: left and right tick deltas
//   and the time step. o_res returns one result per request: x/y position,
//   heading, filtered linear and angular rate and both tick totals.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle
//   by the user; the block itself does not enforce this.
// Processing:
//   One request at a time. Seven products pass a shared bit-serial multiplier;
//   heading reduction runs overlapped with two rate dividers, and CORDIC runs
//   CORDIC_STEPS iterations.
// Reset:
//   Totals, heading, position and filters clear; registers take their defaults.
// Stall:
//   A finished result waits in the output register; the next request is taken
//   meanwhile and its result holds until the receiver takes the first.
// ----------------------------------------------------------------------------
module diff_drive_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    ddo_in_if.sink      i_req,
    ddo_out_if.source   o_res
);
    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int PW = ddo_pkg::PROD_W;
    localparam int MW = ddo_pkg::MUL_W;

    ddo_pkg::t_state r_state, n_state;

    logic [23:0] r_dpt, r_iws;
    logic [16:0] r_lgain, r_again;

    logic signed [15:0] r_l, r_r;
    logic [15:0]        r_dt;
    logic signed [31:0] r_lsum, r_rsum, r_heading, r_lf, r_af, r_dist, r_turn;
    logic signed [47:0] r_x, r_y;
    logic signed [MW-1:0] r_ta;
    logic signed [53:0] r_turn28;
    logic               r_mneg;
    logic [54:0]        r_rem, r_modv;
    logic [4:0]         r_k;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic               r_cneg;
    logic [IW-1:0]      r_it;
    logic signed [31:0] r_lr, r_ar;
    logic               r_mwait;

    logic               r_ovalid;
    logic signed [47:0] r_ox, r_oy;
    logic signed [30:0] r_oh;
    logic signed [31:0] r_olr, r_oar, r_olt, r_ort;

    logic                 mul_start, mul_done, mul_state;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic                 ldiv_busy, adiv_busy, div_start;
    logic [31:0]          ldiv_q, adiv_q;

    logic signed [16:0] w_lr_sum, w_lr_diff;
    logic signed [54:0] w_hsum;
    logic signed [31:0] w_sin, w_cos, w_h0, w_h, w_ysh, w_xsh, w_atan;
    logic [30:0]        w_rem31;

    always_comb begin
        w_lr_sum = 17'(r_l) + 17'(r_r);
        w_lr_diff = 17'(r_l) - 17'(r_r);
        w_hsum = 55'(r_heading) + 55'(r_turn28);
        w_sin = r_cneg ? -r_cy : r_cy;
        w_cos = r_cneg ? -r_cx : r_cx;
        w_rem31 = r_rem[30:0];
        if (r_mneg && (w_rem31 != '0)) begin
            w_h0 = ddo_pkg::TWO_PI_Q28 - $signed({1'b0, w_rem31});
        end else begin
            w_h0 = $signed({1'b0, w_rem31});
        end
        w_h = (w_h0 > ddo_pkg::PI_Q28) ? (w_h0 - ddo_pkg::TWO_PI_Q28) : w_h0;
        w_ysh = r_cy >>> r_it;
        w_xsh = r_cx >>> r_it;
        w_atan = ddo_pkg::atan_q28(5'(r_it));
    end

    always_comb begin
        mul_state = 1'b1;
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ddo_pkg::ST_DIST: begin
                mul_a = MW'(w_lr_sum);
                mul_b = MW'({1'b0, r_dpt});
            end
            ddo_pkg::ST_TURN_A: begin
                mul_a = MW'(w_lr_diff);
                mul_b = MW'({1'b0, r_dpt});
            end
            ddo_pkg::ST_TURN_B: begin
                mul_a = r_ta;
                mul_b = MW'({1'b0, r_iws});
            end
            ddo_pkg::ST_LIN_FILT: begin
                mul_a = MW'(r_dist) - MW'(r_lf);
                mul_b = MW'({1'b0, r_lgain});
            end
            ddo_pkg::ST_ANG_FILT: begin
                mul_a = MW'(r_turn) - MW'(r_af);
                mul_b = MW'({1'b0, r_again});
            end
            ddo_pkg::ST_POS_X: begin
                mul_a = MW'(r_dist);
                mul_b = MW'(w_sin);
            end
            ddo_pkg::ST_POS_Y: begin
                mul_a = MW'(r_dist);
                mul_b = MW'(w_cos);
            end
            default: mul_state = 1'b0;
        endcase
        mul_start = mul_state && !r_mwait;
    end

    ddo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    assign div_start = (r_state == ddo_pkg::ST_HEAD_SET);

    ddo_div u_ldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_lf[31] ? 32'(-r_lf) : 32'(r_lf)),
        .i_den   (r_dt),
        .o_busy  (ldiv_busy),
        .o_quo   (ldiv_q)
    );

    ddo_div u_adiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_af[31] ? 32'(-r_af) : 32'(r_af)),
        .i_den   (r_dt),
        .o_busy  (adiv_busy),
        .o_quo   (adiv_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ddo_pkg::ST_IDLE: if (i_req.valid) n_state = ddo_pkg::ST_DIST;
            ddo_pkg::ST_DIST: if (mul_done) n_state = ddo_pkg::ST_TURN_A;
            ddo_pkg::ST_TURN_A: if (mul_done) n_state = ddo_pkg::ST_TURN_B;
            ddo_pkg::ST_TURN_B: if (mul_done) n_state = ddo_pkg::ST_LIN_FILT;
            ddo_pkg::ST_LIN_FILT: if (mul_done) n_state = ddo_pkg::ST_ANG_FILT;
            ddo_pkg::ST_ANG_FILT: if (mul_done) n_state = ddo_pkg::ST_HEAD_SET;
            ddo_pkg::ST_HEAD_SET: n_state = ddo_pkg::ST_HEAD_MOD;
            ddo_pkg::ST_HEAD_MOD: if (r_k == '0) n_state = ddo_pkg::ST_HEAD_FIN;
            ddo_pkg::ST_HEAD_FIN: begin
                if (!ldiv_busy && !adiv_busy) n_state = ddo_pkg::ST_CORD_INIT;
            end
            ddo_pkg::ST_CORD_INIT: n_state = ddo_pkg::ST_CORD;
            ddo_pkg::ST_CORD: begin
                if (r_it == IW'(CORDIC_STEPS - 1)) n_state = ddo_pkg::ST_POS_X;
            end
            ddo_pkg::ST_POS_X: if (mul_done) n_state = ddo_pkg::ST_POS_Y;
            ddo_pkg::ST_POS_Y: if (mul_done) n_state = ddo_pkg::ST_DONE;
            ddo_pkg::ST_DONE: if (!r_ovalid || o_res.ready) n_state = ddo_pkg::ST_IDLE;
            default: n_state = ddo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpt <= 24'd65536;
            r_iws <= 24'd655360;
            r_lgain <= 17'd32768;
            r_again <= 17'd32768;
            r_lsum <= '0;
            r_rsum <= '0;
            r_heading <= '0;
            r_x <= '0;
            r_y <= '0;
            r_lf <= '0;
            r_af <= '0;
            r_mwait <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (ddo_pkg::t_cfg_idx'(i_cfg_idx))
                    ddo_pkg::CFG_DIST_PER_TICK: r_dpt <= i_cfg_data;
                    ddo_pkg::CFG_INV_WHEEL_SEP: r_iws <= i_cfg_data;
                    ddo_pkg::CFG_LIN_GAIN: r_lgain <= i_cfg_data[16:0];
                    ddo_pkg::CFG_ANG_GAIN: r_again <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (mul_start) begin
                r_mwait <= 1'b1;
            end else if (mul_done) begin
                r_mwait <= 1'b0;
            end
            if (o_res.valid && o_res.ready && (r_state != ddo_pkg::ST_DONE)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ddo_pkg::ST_IDLE: begin
                    if (i_req.valid) begin
                        r_l <= i_req.left_delta;
                        r_r <= i_req.right_delta;
                        r_dt <= i_req.time_step;
                        r_lsum <= r_lsum + 32'(i_req.left_delta);
                        r_rsum <= r_rsum + 32'(i_req.right_delta);
                    end
                end
                ddo_pkg::ST_DIST: if (mul_done) r_dist <= ddo_pkg::sat32(mul_p >>> 9);
                ddo_pkg::ST_TURN_A: if (mul_done) r_ta <= mul_p[MW+7:8];
                ddo_pkg::ST_TURN_B: begin
                    if (mul_done) begin
                        r_turn28 <= mul_p[57:4];
                        r_turn <= ddo_pkg::sat32(mul_p >>> 16);
                    end
                end
                ddo_pkg::ST_LIN_FILT: begin
                    if (mul_done) r_lf <= ddo_pkg::sat32((mul_p >>> 16) + PW'(r_lf));
                end
                ddo_pkg::ST_ANG_FILT: begin
                    if (mul_done) r_af <= ddo_pkg::sat32((mul_p >>> 16) + PW'(r_af));
                end
                ddo_pkg::ST_HEAD_SET: begin
                    r_mneg <= w_hsum[54];
                    r_rem <= w_hsum[54] ? 55'(-w_hsum) : 55'(w_hsum);
                    r_modv <= 55'(ddo_pkg::TWO_PI_Q28) << ddo_pkg::MOD_STEPS;
                    r_k <= 5'(ddo_pkg::MOD_STEPS);
                end
                ddo_pkg::ST_HEAD_MOD: begin
                    if (r_rem >= r_modv) r_rem <= r_rem - r_modv;
                    r_modv <= r_modv >> 1;
                    r_k <= r_k - 1'b1;
                end
                ddo_pkg::ST_HEAD_FIN: begin
                    r_heading <= w_h;
                    if (r_dt == '0) begin
                        r_lr <= '0;
                        r_ar <= '0;
                    end else begin
                        r_lr <= r_lf[31] ? 32'(-ldiv_q) : 32'(ldiv_q);
                        r_ar <= r_af[31] ? 32'(-adiv_q) : 32'(adiv_q);
                    end
                end
                ddo_pkg::ST_CORD_INIT: begin
                    r_cx <= ddo_pkg::CORDIC_GAIN_Q28;
                    r_cy <= '0;
                    r_it <= '0;
                    if (r_heading > ddo_pkg::HALF_PI_Q28) begin
                        r_cz <= r_heading - ddo_pkg::PI_Q28;
                        r_cneg <= 1'b1;
                    end else if (r_heading < -ddo_pkg::HALF_PI_Q28) begin
                        r_cz <= r_heading + ddo_pkg::PI_Q28;
                        r_cneg <= 1'b1;
                    end else begin
                        r_cz <= r_heading;
                        r_cneg <= 1'b0;
                    end
                end
                ddo_pkg::ST_CORD: begin
                    if (!r_cz[31]) begin
                        r_cx <= r_cx - w_ysh;
                        r_cy <= r_cy + w_xsh;
                        r_cz <= r_cz - w_atan;
                    end else begin
                        r_cx <= r_cx + w_ysh;
                        r_cy <= r_cy - w_xsh;
                        r_cz <= r_cz + w_atan;
                    end
                    r_it <= r_it + 1'b1;
                end
                ddo_pkg::ST_POS_X: begin
                    if (mul_done) r_x <= ddo_pkg::sat48((mul_p >>> 28) + PW'(r_x));
                end
                ddo_pkg::ST_POS_Y: begin
                    if (mul_done) r_y <= ddo_pkg::sat48((mul_p >>> 28) + PW'(r_y));
                end
                ddo_pkg::ST_DONE: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid <= 1'b1;
                        r_ox <= r_x;
                        r_oy <= r_y;
                        r_oh <= r_heading[30:0];
                        r_olr <= r_lr;
                        r_oar <= r_ar;
                        r_olt <= r_lsum;
                        r_ort <= r_rsum;
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_req.ready = (r_state == ddo_pkg::ST_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.pos_x = r_ox;
    assign o_res.pos_y = r_oy;
    assign o_res.heading_angle = r_oh;
    assign o_res.linear_rate = r_olr;
    assign o_res.angular_rate = r_oar;
    assign o_res.left_total = r_olt;
    assign o_res.right_total = r_ort;

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ddo_pkg::ST_DONE))
        else $error("result loaded outside done state");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_heading <= ddo_pkg::PI_Q28) && (r_heading >= -ddo_pkg::PI_Q28))
        else $error("heading outside +-pi");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == ddo_pkg::ST_DIST))
        else $error("request accepted without starting");

    a_mul_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |=> !mul_start)
        else $error("multiplier restarted while busy");
endmodule
